@@ rtl/core/pngcs_pkg.sv @@
// Shared types, constants and the chunk type lookup for the PNG chunk stripper.
package pngcs_pkg;

    localparam int MASK_W      = 14;
    localparam int NUM_TYPES   = 14;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [MASK_W-1:0] MASK_RESET = 14'h3FFF;
    localparam logic [31:0]       TYPE_IDAT  = 32'h4944_4154;

    // Bit i of the strip mask selects entry i of this list.
    localparam logic [31:0] STRIP_TYPES [NUM_TYPES] = '{
        32'h624B_4744,  // bKGD
        32'h6348_524D,  // cHRM
        32'h7352_4742,  // sRGB
        32'h6849_5354,  // hIST
        32'h6943_4350,  // iCCP
        32'h7048_5973,  // pHYs
        32'h7342_4954,  // sBIT
        32'h6741_4D41,  // gAMA
        32'h7350_4C54,  // sPLT
        32'h7449_4D45,  // tIME
        32'h7452_4E53,  // tRNS
        32'h7445_5874,  // tEXt
        32'h6954_5874,  // iTXt
        32'h7A54_5874   // zTXt
    };

    typedef enum logic [1:0] {
        PH_SIG  = 2'd0,
        PH_HDR  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // One unit of output work: a single byte, or an 8-byte header burst sent MSB first.
    // A single byte sits in the top byte of the payload.
    typedef struct packed {
        logic        burst;
        logic [63:0] bytes;
    } job_t;

    function automatic logic strip_hit(input logic [31:0] chunk_type,
                                       input logic [MASK_W-1:0] mask);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (chunk_type == STRIP_TYPES[i] && mask[i])
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

@@ rtl/core/pngcs_front.sv @@
// Front end: walks the PNG chunk structure and queues output jobs.
module pngcs_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [pngcs_pkg::MASK_W-1:0]    cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    input  logic                            in_sof,
    output logic                            push,
    output pngcs_pkg::job_t                 push_job,
    input  logic                            q_ready
);

    pngcs_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [2:0]  sig_cnt_reg, sig_cnt_next, sig_cnt_eff;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next, hdr_cnt_eff;
    logic [63:0] hdr_buf_reg, hdr_buf_next, hdr_buf_eff, hdr_shift;
    logic [32:0] remain_reg, remain_next, remain_eff, remain_dec;
    logic        drop_reg, drop_next, drop_eff;
    logic        idat_reg, idat_next, idat_eff;
    logic        hdr_drop;
    logic [pngcs_pkg::MASK_W-1:0] mask_reg;
    logic        accept;

    assign in_ready = q_ready;
    assign accept   = in_valid & q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= pngcs_pkg::MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            mask_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= pngcs_pkg::PH_SIG;
            sig_cnt_reg <= '0;
            hdr_cnt_reg <= '0;
            hdr_buf_reg <= '0;
            remain_reg  <= '0;
            drop_reg    <= 1'b0;
            idat_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            sig_cnt_reg <= sig_cnt_next;
            hdr_cnt_reg <= hdr_cnt_next;
            hdr_buf_reg <= hdr_buf_next;
            remain_reg  <= remain_next;
            drop_reg    <= drop_next;
            idat_reg    <= idat_next;
        end
    end

    always_comb
    begin
        // A new-file mark restarts the walk before the byte is taken.
        phase_eff   = phase_reg;
        sig_cnt_eff = sig_cnt_reg;
        hdr_cnt_eff = hdr_cnt_reg;
        hdr_buf_eff = hdr_buf_reg;
        remain_eff  = remain_reg;
        drop_eff    = drop_reg;
        idat_eff    = idat_reg;
        if (in_sof)
        begin
            phase_eff   = pngcs_pkg::PH_SIG;
            sig_cnt_eff = '0;
            hdr_cnt_eff = '0;
            hdr_buf_eff = '0;
            remain_eff  = '0;
            drop_eff    = 1'b0;
            idat_eff    = 1'b0;
        end

        hdr_shift  = {hdr_buf_eff[55:0], in_byte};
        hdr_drop   = !idat_eff && pngcs_pkg::strip_hit(hdr_shift[31:0], mask_reg);
        remain_dec = (remain_eff != '0) ? remain_eff - 33'd1 : '0;

        phase_next   = phase_reg;
        sig_cnt_next = sig_cnt_reg;
        hdr_cnt_next = hdr_cnt_reg;
        hdr_buf_next = hdr_buf_reg;
        remain_next  = remain_reg;
        drop_next    = drop_reg;
        idat_next    = idat_reg;
        push         = 1'b0;
        push_job     = '{burst: 1'b0, bytes: {in_byte, 56'd0}};

        if (accept)
        begin
            phase_next   = phase_eff;
            sig_cnt_next = sig_cnt_eff;
            hdr_cnt_next = hdr_cnt_eff;
            hdr_buf_next = hdr_buf_eff;
            remain_next  = remain_eff;
            drop_next    = drop_eff;
            idat_next    = idat_eff;
            case (phase_eff)
                pngcs_pkg::PH_HDR:
                begin
                    hdr_buf_next = hdr_shift;
                    if (hdr_cnt_eff == 3'd7)
                    begin
                        hdr_cnt_next = '0;
                        drop_next    = hdr_drop;
                        idat_next    = idat_eff | (hdr_shift[31:0] == pngcs_pkg::TYPE_IDAT);
                        remain_next  = {1'b0, hdr_shift[63:32]} + 33'd4;
                        phase_next   = pngcs_pkg::PH_DATA;
                        push         = !hdr_drop;
                        push_job     = '{burst: 1'b1, bytes: hdr_shift};
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_eff + 3'd1;
                    end
                end
                pngcs_pkg::PH_DATA:
                begin
                    remain_next = remain_dec;
                    if (remain_dec == '0)
                    begin
                        phase_next = pngcs_pkg::PH_HDR;
                        drop_next  = 1'b0;
                    end
                    push = !drop_eff;
                end
                default:
                begin
                    // Signature bytes pass unchecked; an unused phase code acts the same.
                    push = 1'b1;
                    if (sig_cnt_eff == 3'd7)
                    begin
                        sig_cnt_next = '0;
                        hdr_cnt_next = '0;
                        hdr_buf_next = '0;
                        phase_next   = pngcs_pkg::PH_HDR;
                    end
                    else
                    begin
                        sig_cnt_next = sig_cnt_eff + 3'd1;
                        phase_next   = pngcs_pkg::PH_SIG;
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/core/pngcs_queue.sv @@
// Short job queue between the chunk walker and the output serializer.
module pngcs_queue #(
    parameter int DEPTH = pngcs_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pngcs_pkg::job_t push_job,
    output logic            push_ready,
    input  logic            pop,
    output pngcs_pkg::job_t pop_job,
    output logic            pop_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pngcs_pkg::job_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/pngcs_back.sv @@
// Back end: turns queued jobs into output words, one registered word per cycle while the receiver is ready.
module pngcs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    input  pngcs_pkg::job_t job,
    output logic            job_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic        valid_reg, valid_next;
    logic        burst_reg, burst_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] data_reg, data_next;
    logic        load;

    assign out_valid = valid_reg;
    assign out_byte  = data_reg[63:56];
    assign out_last  = !burst_reg || (cnt_reg == 3'd7);
    assign load      = !valid_reg || (out_ready && out_last);
    assign job_pop   = load && job_valid;

    always_comb
    begin
        valid_next = valid_reg;
        burst_next = burst_reg;
        cnt_next   = cnt_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = job_valid;
            burst_next = job.burst;
            cnt_next   = '0;
            data_next  = job.bytes;
        end
        else if (out_ready)
        begin
            cnt_next  = cnt_reg + 3'd1;
            data_next = {data_reg[55:0], 8'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            burst_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            burst_reg <= burst_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ rtl/core/png_ancillary_chunk_stripper.sv @@
// Top level of the PNG ancillary chunk stripper.
// This block takes a PNG file one byte per input word and sends out the same file with the
// selected ancillary chunks removed. The 8-byte signature passes unchanged and unchecked. After
// that each chunk's 4 length bytes and 4 type bytes are held back; when the eighth header byte
// arrives the type is compared against the 14 listed ancillary types (bKGD, cHRM, sRGB, hIST,
// iCCP, pHYs, sBIT, gAMA, sPLT, tIME, tRNS, tEXt, iTXt, zTXt, in strip mask bit order). A chunk
// whose type matches and whose mask bit is set is dropped whole, data and CRC included, as long
// as no IDAT chunk has been seen in the file; from the first IDAT on everything passes. A kept
// header leaves as a burst of 8 words, and the full 32-bit length is honored. An input word
// with tuser set starts a new file and restarts the walk at signature byte 0. On the output,
// tlast marks the last word that one input byte produced, so it is high on every single byte
// and on the eighth word of a header burst. An input word is accepted whenever the four-entry
// job queue between the chunk walker and the output serializer has room, whether or not the
// byte leads to output. A passed byte is registered in the job queue and then in the output
// register before it is offered on the output. Output runs at one word per cycle while the
// receiver is ready, so a header burst holds the serializer while the walker keeps queuing
// the bytes that follow the header; the queue is full after four of them and the input stalls
// until the burst has gone, even when the receiver never stalls. The strip mask is written
// through cfg_wr_en/cfg_wr_data, by the user only while no file is in flight; the block
// itself does not enforce this.
module png_ancillary_chunk_stripper #(
    parameter int QUEUE_DEPTH = pngcs_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pngcs_pkg::MASK_W-1:0]  cfg_wr_data,   // strip_mask
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,       // [7:0] data_byte
    input  logic                          s_tuser,       // [0] start_of_file
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,       // [7:0] out_byte
    output logic                          m_tlast        // run_last
);

    logic            push, push_ready, pop, pop_valid;
    pngcs_pkg::job_t push_job, pop_job;

    // The walker classifies every byte and queues only words that leave the block.
    pngcs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_sof      (s_tuser),
        .push        (push),
        .push_job    (push_job),
        .q_ready     (push_ready)
    );

    pngcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid)
    );

    // The serializer owns the output register, so a stalled consumer never blocks the walker
    // until the queue fills.
    pngcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job       (pop_job),
        .job_pop   (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

@@ rtl/core/pngcs_chk.sv @@
// Port-level checker for the PNG chunk stripper, bound to the top level.
module pngcs_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic [2:0] run_cnt_reg;

    // Counts words of the current output run that have gone out without tlast.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            run_cnt_reg <= m_tlast ? 3'd0 : run_cnt_reg + 3'd1;
        end
    end

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // A header burst never pauses once it has started.
    a_burst_dense: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside header burst");

    // No run is longer than a header burst of eight words.
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && run_cnt_reg == 3'd7 |-> m_tlast)
        else $error("output run longer than eight words");

    // Nothing comes out right after reset.
    a_reset_quiet: assert property (@(posedge clk)
        !$past(rst_n) |-> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

bind png_ancillary_chunk_stripper pngcs_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the PNG ancillary chunk stripper, with its own model of the chunk walk.
module tb_top;

    import pngcs_pkg::*;

    // A passed byte goes through the job queue and the output register before it is taken from
    // the output. Held header bytes cause no output, so after the last expected word has come
    // the block may still be holding bytes. This many extra cycles cover that before the mask is
    // written or the run ends.
    localparam int SETTLE_CYCLES = 12;

    // The standard 8-byte PNG signature. The block does not check it, but most files carry it.
    localparam logic [7:0] PNG_SIGNATURE [8] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };

    // Critical chunk types that are never on the strip list.
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // One output word: the stripped byte and the flag that ends the run of one input byte.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_word_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [MASK_W-1:0] cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;
    logic              m_tlast;

    png_ancillary_chunk_stripper i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // Words the stripped stream must still deliver, oldest first.
    out_word_t   stripped_words [$];
    int          mismatch_count;
    int          sent_words;

    // When calm is set neither side idles at random. A hold request makes the receiver stall
    // for that many cycles in a row.
    bit          calm;
    int          hold_request;
    int          hold_left;

    // Our own copy of the walk state and of the strip mask.
    phase_t            walk_phase;
    logic [3:0]        sig_seen;
    logic [63:0]       hdr_shift;
    logic [3:0]        hdr_held;
    logic [32:0]       body_left;
    logic              chunk_dropped;
    logic              idat_found;
    logic [MASK_W-1:0] mask_model;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // True when a chunk of this type is to be removed under the current mask. Only the
    // ancillary types on the list qualify, and only before the file's first IDAT.
    function automatic logic chunk_is_stripped(input logic [31:0] ctype);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (ctype == STRIP_TYPES[i] && mask_model[i])
            begin
                hit = 1'b1;
            end
        end
        return hit && !idat_found;
    endfunction

    // Advance the model by one accepted input word and queue the words it must produce.
    task automatic strip_predict(input logic [7:0] b, input logic sof);
        logic [31:0] ctype;
        logic        was_dropped;
        // A new file mark wipes the walk but keeps the mask; the byte is signature byte 0.
        if (sof)
        begin
            walk_phase    = PH_SIG;
            sig_seen      = '0;
            hdr_shift     = '0;
            hdr_held      = '0;
            body_left     = '0;
            chunk_dropped = 1'b0;
            idat_found    = 1'b0;
        end
        case (walk_phase)
            PH_HDR:
            begin
                // Length and type are held back until the eighth byte decides the chunk.
                hdr_shift = {hdr_shift[55:0], b};
                hdr_held  = hdr_held + 4'd1;
                if (hdr_held == 4'd8)
                begin
                    hdr_held      = '0;
                    ctype         = hdr_shift[31:0];
                    chunk_dropped = chunk_is_stripped(ctype);
                    if (ctype == TYPE_IDAT)
                    begin
                        idat_found = 1'b1;
                    end
                    // The 33-bit count takes the full 32-bit length plus the CRC.
                    body_left  = {1'b0, hdr_shift[63:32]} + 33'd4;
                    walk_phase = PH_DATA;
                    if (!chunk_dropped)
                    begin
                        for (int k = 0; k < 8; k++)
                        begin
                            stripped_words.push_back('{hdr_shift[8*(7-k) +: 8], k == 7});
                        end
                    end
                end
            end
            PH_DATA:
            begin
                was_dropped = chunk_dropped;
                if (body_left != '0)
                begin
                    body_left = body_left - 33'd1;
                end
                if (body_left == '0)
                begin
                    walk_phase    = PH_HDR;
                    chunk_dropped = 1'b0;
                end
                if (!was_dropped)
                begin
                    stripped_words.push_back('{b, 1'b1});
                end
            end
            default:
            begin
                // Signature bytes pass whatever they hold; the unused code acts the same way.
                walk_phase = PH_SIG;
                sig_seen   = sig_seen + 4'd1;
                if (sig_seen >= 4'd8)
                begin
                    sig_seen   = '0;
                    walk_phase = PH_HDR;
                    hdr_held   = '0;
                    hdr_shift  = '0;
                end
                stripped_words.push_back('{b, 1'b1});
            end
        endcase
    endtask

    // Offer one file byte, wait for the handshake, then update the model. Called and left at
    // a falling edge, so the valid is driven once per time step.
    task automatic push_file_byte(input logic [7:0] b, input logic sof);
        if (!calm && $urandom_range(0, 99) < 17)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        strip_predict(b, sof);
        sent_words++;
        @(negedge clk);
    endtask

    // The first byte of a file always carries the new file mark.
    task automatic push_signature(input bit genuine);
        for (int i = 0; i < 8; i++)
        begin
            push_file_byte(genuine ? PNG_SIGNATURE[i] : 8'($urandom), i == 0);
        end
    endtask

    // Send one chunk: big-endian length, type, then data and CRC. A non-negative limit cuts the
    // body short, which leaves the chunk open until the next new file mark.
    task automatic push_chunk(input logic [31:0] len, input logic [31:0] ctype,
                              input longint limit);
        longint body;
        body = longint'(len) + 64'sd4;
        if (limit >= 0 && limit < body)
        begin
            body = limit;
        end
        for (int i = 3; i >= 0; i--)
        begin
            push_file_byte(len[8*i +: 8], 1'b0);
        end
        for (int i = 3; i >= 0; i--)
        begin
            push_file_byte(ctype[8*i +: 8], 1'b0);
        end
        for (longint j = 0; j < body; j++)
        begin
            push_file_byte(8'($urandom), 1'b0);
        end
    endtask

    // Listed ancillary types most often, plus IDAT, critical types, near misses in letter case
    // and fully random types.
    function automatic logic [31:0] pick_chunk_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            return STRIP_TYPES[$urandom_range(0, NUM_TYPES - 1)];
        end
        else if (r < 57)
        begin
            return TYPE_IDAT;
        end
        else if (r < 65)
        begin
            return TYPE_IHDR;
        end
        else if (r < 70)
        begin
            return TYPE_PLTE;
        end
        else if (r < 75)
        begin
            return TYPE_IEND;
        end
        else if (r < 87)
        begin
            return STRIP_TYPES[$urandom_range(0, NUM_TYPES - 1)] ^
                   (32'h20 << (8 * $urandom_range(0, 3)));
        end
        return $urandom;
    endfunction

    // One random file. Most are well-formed chunk walks with random content; a few are plain
    // noise or end in a chunk that is cut short, sometimes with a huge random length.
    task automatic push_random_file();
        int          nchunks;
        int          len;
        logic [31:0] ctype;
        if ($urandom_range(0, 99) < 10)
        begin
            len = $urandom_range(4, 14);
            for (int i = 0; i < len; i++)
            begin
                push_file_byte(8'($urandom), (i == 0) || ($urandom_range(0, 19) == 0));
            end
        end
        else
        begin
            push_signature($urandom_range(0, 7) != 0);
            nchunks = $urandom_range(1, 3);
            for (int c = 0; c < nchunks; c++)
            begin
                ctype = pick_chunk_type();
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24)
                                                    : $urandom_range(0, 5);
                if (c == nchunks - 1 && $urandom_range(0, 19) == 0)
                begin
                    push_chunk($urandom, ctype, $urandom_range(0, 6));
                end
                else if (c == nchunks - 1 && $urandom_range(0, 9) == 0)
                begin
                    push_chunk(len, ctype, $urandom_range(0, len + 3));
                end
                else
                begin
                    push_chunk(len, ctype, -1);
                end
            end
        end
    endtask

    task automatic run_random_files(input int words);
        int start;
        start = sent_words;
        while (sent_words - start < words)
        begin
            push_random_file();
        end
    endtask

    // The sender pauses until every expected word has come and the block has settled.
    task automatic drain_stripped();
        s_tvalid <= 1'b0;
        while (stripped_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Only called once the block is idle, so the model can take the new mask at once.
    task automatic write_strip_mask(input logic [MASK_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        mask_model  = value;
    endtask

    // A new file mark in the middle of the signature restarts it, with byte extremes.
    task automatic test_restart_in_signature();
        push_file_byte(8'hFF, 1'b1);
        push_file_byte(8'h00, 1'b0);
        push_file_byte(8'h80, 1'b0);
        push_signature(1'b1);
    endtask

    // An IDAT with the largest length passes and stays open; the next file mark ends it.
    task automatic test_huge_length();
        push_chunk(32'hFFFF_FFFF, TYPE_IDAT, 3);
        drain_stripped();
    endtask

    task automatic test_strip_all();
        write_strip_mask({MASK_W{1'b1}});
        run_random_files(25);
        drain_stripped();
    endtask

    task automatic test_strip_none();
        write_strip_mask('0);
        run_random_files(15);
        drain_stripped();
    endtask

    task automatic test_strip_alternating();
        write_strip_mask(14'h2AAA);
        run_random_files(15);
        drain_stripped();
        write_strip_mask(14'h1555);
        run_random_files(15);
        drain_stripped();
    endtask

    task automatic test_strip_random();
        write_strip_mask(MASK_W'($urandom));
        run_random_files(15);
        drain_stripped();
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering bursts of kept
    // words, so the job queue fills and the input side must stall.
    task automatic test_receiver_hold();
        calm         = 1'b1;
        hold_request = 400;
        push_signature(1'b1);
        push_chunk(32'd6, TYPE_IHDR, -1);
        push_chunk(32'd12, TYPE_IDAT, -1);
        drain_stripped();
        calm = 1'b0;
    endtask

    // A long stretch in which neither side ever idles.
    task automatic test_no_idle_stretch();
        calm = 1'b1;
        run_random_files(25);
        drain_stripped();
        calm = 1'b0;
    endtask

    // Receiver side: random stalls, or a long counted hold when one is requested.
    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // Every accepted output word is compared with the oldest expected word.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (stripped_words.size() == 0)
            begin
                $error("unexpected output word: out_byte %02h run_last %0b", m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                if (m_tdata !== stripped_words[0].out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h",
                           stripped_words[0].out_byte, m_tdata);
                    mismatch_count++;
                end
                if (m_tlast !== stripped_words[0].run_last)
                begin
                    $error("run_last: expected %0b, got %0b",
                           stripped_words[0].run_last, m_tlast);
                    mismatch_count++;
                end
                void'(stripped_words.pop_front());
            end
        end
    end

    // The slowest correct run is far shorter than this.
    initial
    begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        calm           = 1'b0;
        hold_request   = 0;
        mismatch_count = 0;
        sent_words     = 0;
        walk_phase     = PH_SIG;
        sig_seen       = '0;
        hdr_shift      = '0;
        hdr_held       = '0;
        body_left      = '0;
        chunk_dropped  = 1'b0;
        idat_found     = 1'b0;
        mask_model     = MASK_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_restart_in_signature();
        test_huge_length();
        test_strip_all();
        test_receiver_hold();
        test_strip_none();
        test_strip_alternating();
        test_no_idle_stretch();
        test_strip_random();

        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
